@@ design/snfs_pkg.sv @@
// shared types and constants for the spi nor flash sequencer
// depends on nothing
package snfs_pkg;

  localparam int DefPageSize = 256;

  localparam logic [2:0] REQ_ID    = 3'd0;
  localparam logic [2:0] REQ_WBEG  = 3'd1;
  localparam logic [2:0] REQ_WDATA = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_ERASE = 3'd4;
  localparam logic [2:0] REQ_REPLY = 3'd5;

  localparam logic [7:0] OPC_RDID  = 8'h9F;
  localparam logic [7:0] OPC_PP4   = 8'h12;
  localparam logic [7:0] OPC_PP3   = 8'h02;
  localparam logic [7:0] OPC_RD4   = 8'h13;
  localparam logic [7:0] OPC_RD3   = 8'h03;
  localparam logic [7:0] OPC_CE    = 8'hC7;
  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_RDSR  = 8'h05;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ID_BAD   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic [1:0] REG_FOUR  = 2'd0;
  localparam logic [1:0] REG_MANUF = 2'd1;
  localparam logic [1:0] REG_DEV   = 2'd2;

  // one result item
  typedef struct packed {
    logic        mosi_valid;
    logic [7:0]  mosi_byte;
    logic        frame_end;
    logic        wants_reply;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        op_done;
    logic [1:0]  status;
    logic [31:0] next_address;
    logic        last;
  } res_t;

  localparam int ResW = $bits(res_t);

  // one planned item handed from front to back
  typedef struct packed {
    res_t [7:0] res;
    logic [3:0] cnt;
  } plan_t;

endpackage

@@ design/spi_nor_flash_sequencer.sv @@
// top level of the spi nor flash command sequencer: config registers, front, back
// depends on snfs_pkg, snfs_front, snfs_back
// path: an accepted item is held in the front's plan register, then written into the back's
// plan queue when it has room, and its first result is shown from the queue head
// throughput: one result per cycle while popped; an item causes one to eight results
// the front takes a new item each cycle while the two-entry plan queue has room
// reset: synchronous, active high; clears phase, counters and queue; presets config
module spi_nor_flash_sequencer import snfs_pkg::*; #(
  parameter int PageSize = DefPageSize
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [31:0] address,
  input  logic [15:0] byte_count,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  reply_byte,
  output logic        empty,
  input  logic        pop,
  output logic        mosi_valid,
  output logic [7:0]  mosi_byte,
  output logic        frame_end,
  output logic        wants_reply,
  output logic        read_valid,
  output logic [7:0]  read_byte,
  output logic        op_done,
  output logic [1:0]  status,
  output logic [31:0] next_address,
  output logic        last
);

  // configuration registers
  logic        four_byte_address;
  logic [7:0]  expected_manufacturer;
  logic [15:0] expected_device;
  logic [1:0]  reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      four_byte_address <= 1'b0;
      expected_manufacturer <= 8'hEF;
      expected_device <= 16'h4018;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (reg_sel)
        REG_FOUR:  four_byte_address <= pwdata[0];
        REG_MANUF: expected_manufacturer <= pwdata[7:0];
        REG_DEV:   expected_device <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_sel)
        REG_FOUR:  prdata = {31'b0, four_byte_address};
        REG_MANUF: prdata = {24'b0, expected_manufacturer};
        REG_DEV:   prdata = {16'b0, expected_device};
        default:   prdata = '0;
      endcase
    end
  end

  // front and back joined by the plan register and queue
  logic  in_ready, plan_valid, plan_ready;
  plan_t plan;
  res_t  res;

  assign full = !in_ready;

  snfs_front #(.PageSize(PageSize)) u_front (
    .clk, .rst,
    .in_valid(push), .in_ready,
    .req_type, .address, .byte_count, .data_byte, .reply_byte,
    .four_byte_address, .expected_manufacturer, .expected_device,
    .plan_valid, .plan_ready, .plan
  );

  snfs_back u_back (
    .clk, .rst,
    .plan_valid, .plan_ready, .plan,
    .empty, .pop, .res
  );

  assign mosi_valid = res.mosi_valid;
  assign mosi_byte = res.mosi_byte;
  assign frame_end = res.frame_end;
  assign wants_reply = res.wants_reply;
  assign read_valid = res.read_valid;
  assign read_byte = res.read_byte;
  assign op_done = res.op_done;
  assign status = res.status;
  assign next_address = res.next_address;
  assign last = res.last;

  // op_done excludes a mosi byte, wants_reply needs one, an ignored item is last
  a_done_no_mosi: assert property (@(posedge clk) disable iff (rst)
    !empty && op_done |-> !mosi_valid) else $error("done with mosi byte");
  a_reply_needs_byte: assert property (@(posedge clk) disable iff (rst)
    !empty && wants_reply |-> mosi_valid) else $error("reply wanted without byte");
  a_ignored_last: assert property (@(posedge clk) disable iff (rst)
    !empty && status == ST_IGNORED |-> last) else $error("ignored item not single");

endmodule

@@ design/snfs_front.sv @@
// front part: accepts items, tracks the command state, plans the results
// depends on snfs_pkg
module snfs_front import snfs_pkg::*; #(
  parameter int PageSize = DefPageSize
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] address,
  input  logic [15:0] byte_count,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  reply_byte,
  input  logic        four_byte_address,
  input  logic [7:0]  expected_manufacturer,
  input  logic [15:0] expected_device,
  output logic        plan_valid,
  input  logic        plan_ready,
  output plan_t       plan
);

  localparam int PgW = $clog2(PageSize);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_ID    = 5'b00010,
    PH_WDATA = 5'b00100,
    PH_POLL  = 5'b01000,
    PH_RDATA = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic        erase_op, erase_op_next;
  logic [31:0] cursor_address, cursor_address_next;
  logic [12:0] chunk_left, chunk_left_next;
  logic [15:0] total_left, total_left_next;
  logic [23:0] id_bytes, id_bytes_next;
  plan_t       pl;

  assign in_ready = !plan_valid || plan_ready;

  function automatic res_t mk(input logic v, input logic [7:0] b, input logic fe,
                              input logic wr);
    res_t r;
    r = '0;
    r.mosi_valid = v;
    r.mosi_byte = b;
    r.frame_end = fe;
    r.wants_reply = wr;
    return r;
  endfunction

  function automatic res_t mkdone(input logic [1:0] st, input logic [31:0] na);
    res_t r;
    r = '0;
    r.op_done = 1'b1;
    r.status = st;
    r.next_address = na;
    return r;
  endfunction

  // page-space and chunk sizing for a chunk at cursor, or at address on a write begin
  logic [31:0] open_addr;
  logic [15:0] open_total;
  logic [PgW:0] space;
  logic [12:0] open_chunk;

  always_comb begin
    space = (PgW+1)'(PageSize) - {1'b0, open_addr[PgW-1:0]};
    if ({3'b0, open_total} < 19'(space)) open_chunk = 13'(open_total);
    else open_chunk = 13'(space);
  end

  always_comb begin
    logic [3:0]  k;
    logic [3:0]  km;
    logic [31:0] a;
    logic [7:0]  opc;
    logic        ok;
    logic [23:0] idn;
    logic [15:0] tl;
    logic [12:0] cl;
    k = '0; km = '0; a = '0; opc = '0; ok = 1'b0; idn = '0; tl = '0; cl = '0;
    pl = '0;
    phase_next = phase;
    erase_op_next = erase_op;
    cursor_address_next = cursor_address;
    chunk_left_next = chunk_left;
    total_left_next = total_left;
    id_bytes_next = id_bytes;
    open_addr = cursor_address;
    open_total = total_left;
    if (phase == PH_IDLE && req_type == REQ_WBEG) begin
      open_addr = address;
      open_total = byte_count;
    end

    if (phase == PH_IDLE && (req_type == REQ_ID || req_type == REQ_WBEG ||
        req_type == REQ_READ || req_type == REQ_ERASE)) begin
      case (req_type)
        REQ_ID: begin
          phase_next = PH_ID;
          chunk_left_next = 13'd3;
          id_bytes_next = '0;
          pl.res[0] = mk(1'b1, OPC_RDID, 1'b0, 1'b0);
          pl.res[1] = mk(1'b1, 8'h00, 1'b0, 1'b1);
          pl.res[2] = mk(1'b1, 8'h00, 1'b0, 1'b1);
          pl.res[3] = mk(1'b1, 8'h00, 1'b1, 1'b1);
          k = 4'd4;
        end
        REQ_WBEG: begin
          if (byte_count > 16'(PageSize)) begin
            pl.res[0] = mkdone(ST_TOO_LONG, address);
            k = 4'd1;
          end else begin
            erase_op_next = 1'b0;
            cursor_address_next = address;
            total_left_next = byte_count;
            chunk_left_next = open_chunk;
            opc = four_byte_address ? OPC_PP4 : OPC_PP3;
            pl.res[0] = mk(1'b1, OPC_WREN, 1'b1, 1'b0);
            pl.res[1] = mk(1'b1, opc, 1'b0, 1'b0);
            if (four_byte_address) begin
              pl.res[2] = mk(1'b1, address[31:24], 1'b0, 1'b0);
              pl.res[3] = mk(1'b1, address[23:16], 1'b0, 1'b0);
              pl.res[4] = mk(1'b1, address[15:8], 1'b0, 1'b0);
              pl.res[5] = mk(1'b1, address[7:0], open_chunk == 0, 1'b0);
              k = 4'd6;
            end else begin
              pl.res[2] = mk(1'b1, address[23:16], 1'b0, 1'b0);
              pl.res[3] = mk(1'b1, address[15:8], 1'b0, 1'b0);
              pl.res[4] = mk(1'b1, address[7:0], open_chunk == 0, 1'b0);
              k = 4'd5;
            end
            if (open_chunk == 0) begin
              phase_next = PH_POLL;
              pl.res[k[2:0]] = mk(1'b1, OPC_RDSR, 1'b0, 1'b0);
              pl.res[k[2:0] + 3'd1] = mk(1'b1, 8'h00, 1'b1, 1'b1);
              k = k + 4'd2;
            end else begin
              phase_next = PH_WDATA;
            end
          end
        end
        REQ_READ: begin
          total_left_next = byte_count;
          opc = four_byte_address ? OPC_RD4 : OPC_RD3;
          pl.res[0] = mk(1'b1, opc, 1'b0, 1'b0);
          if (four_byte_address) begin
            pl.res[1] = mk(1'b1, address[31:24], 1'b0, 1'b0);
            pl.res[2] = mk(1'b1, address[23:16], 1'b0, 1'b0);
            pl.res[3] = mk(1'b1, address[15:8], 1'b0, 1'b0);
            pl.res[4] = mk(1'b1, address[7:0], byte_count == 0, 1'b0);
            k = 4'd5;
          end else begin
            pl.res[1] = mk(1'b1, address[23:16], 1'b0, 1'b0);
            pl.res[2] = mk(1'b1, address[15:8], 1'b0, 1'b0);
            pl.res[3] = mk(1'b1, address[7:0], byte_count == 0, 1'b0);
            k = 4'd4;
          end
          if (byte_count == 0) begin
            pl.res[k[2:0]] = mkdone(ST_OK, '0);
          end else begin
            phase_next = PH_RDATA;
            pl.res[k[2:0]] = mk(1'b1, 8'h00, byte_count == 16'd1, 1'b1);
          end
          k = k + 4'd1;
        end
        default: begin
          erase_op_next = 1'b1;
          phase_next = PH_POLL;
          pl.res[0] = mk(1'b1, OPC_WREN, 1'b1, 1'b0);
          pl.res[1] = mk(1'b1, OPC_CE, 1'b1, 1'b0);
          pl.res[2] = mk(1'b1, OPC_RDSR, 1'b0, 1'b0);
          pl.res[3] = mk(1'b1, 8'h00, 1'b1, 1'b1);
          k = 4'd4;
        end
      endcase
    end else if (req_type == REQ_WDATA && phase == PH_WDATA) begin
      cl = chunk_left - 13'd1;
      chunk_left_next = cl;
      total_left_next = total_left - 16'd1;
      cursor_address_next = cursor_address + 32'd1;
      pl.res[0] = mk(1'b1, data_byte, cl == 0, 1'b0);
      k = 4'd1;
      if (cl == 0) begin
        phase_next = PH_POLL;
        pl.res[1] = mk(1'b1, OPC_RDSR, 1'b0, 1'b0);
        pl.res[2] = mk(1'b1, 8'h00, 1'b1, 1'b1);
        k = 4'd3;
      end
    end else if (req_type == REQ_REPLY && phase == PH_ID) begin
      idn = {id_bytes[15:0], reply_byte};
      id_bytes_next = idn;
      cl = chunk_left - 13'd1;
      chunk_left_next = cl;
      if (cl == 0) begin
        ok = idn[23:16] == expected_manufacturer && idn[15:0] == expected_device;
        phase_next = PH_IDLE;
        pl.res[0] = mkdone(ok ? ST_OK : ST_ID_BAD, '0);
      end else begin
        pl.res[0] = mk(1'b0, 8'h00, 1'b0, 1'b0);
      end
      k = 4'd1;
    end else if (req_type == REQ_REPLY && phase == PH_POLL) begin
      if (reply_byte[0]) begin
        pl.res[0] = mk(1'b1, OPC_RDSR, 1'b0, 1'b0);
        pl.res[1] = mk(1'b1, 8'h00, 1'b1, 1'b1);
        k = 4'd2;
      end else if (erase_op) begin
        cursor_address_next = '0;
        phase_next = PH_IDLE;
        pl.res[0] = mkdone(ST_OK, '0);
        k = 4'd1;
      end else if (total_left != 0) begin
        a = cursor_address;
        chunk_left_next = open_chunk;
        opc = four_byte_address ? OPC_PP4 : OPC_PP3;
        pl.res[0] = mk(1'b1, OPC_WREN, 1'b1, 1'b0);
        pl.res[1] = mk(1'b1, opc, 1'b0, 1'b0);
        if (four_byte_address) begin
          pl.res[2] = mk(1'b1, a[31:24], 1'b0, 1'b0);
          pl.res[3] = mk(1'b1, a[23:16], 1'b0, 1'b0);
          pl.res[4] = mk(1'b1, a[15:8], 1'b0, 1'b0);
          pl.res[5] = mk(1'b1, a[7:0], 1'b0, 1'b0);
          k = 4'd6;
        end else begin
          pl.res[2] = mk(1'b1, a[23:16], 1'b0, 1'b0);
          pl.res[3] = mk(1'b1, a[15:8], 1'b0, 1'b0);
          pl.res[4] = mk(1'b1, a[7:0], 1'b0, 1'b0);
          k = 4'd5;
        end
        phase_next = PH_WDATA;
      end else begin
        phase_next = PH_IDLE;
        pl.res[0] = mkdone(ST_OK, cursor_address);
        k = 4'd1;
      end
    end else if (req_type == REQ_REPLY && phase == PH_RDATA) begin
      tl = total_left - 16'd1;
      total_left_next = tl;
      if (tl != 0) begin
        pl.res[0] = mk(1'b1, 8'h00, tl == 16'd1, 1'b1);
      end else begin
        pl.res[0] = mkdone(ST_OK, '0);
        phase_next = PH_IDLE;
      end
      pl.res[0].read_valid = 1'b1;
      pl.res[0].read_byte = reply_byte;
      k = 4'd1;
    end else begin
      pl.res[0] = '0;
      pl.res[0].status = ST_IGNORED;
      k = 4'd1;
    end
    km = k - 4'd1;
    pl.res[km[2:0]].last = 1'b1;
    pl.cnt = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      erase_op <= 1'b0;
      cursor_address <= '0;
      chunk_left <= '0;
      total_left <= '0;
      id_bytes <= '0;
      plan_valid <= 1'b0;
    end else begin
      if (plan_ready) plan_valid <= 1'b0;
      if (in_valid && in_ready) begin
        phase <= phase_next;
        erase_op <= erase_op_next;
        cursor_address <= cursor_address_next;
        chunk_left <= chunk_left_next;
        total_left <= total_left_next;
        id_bytes <= id_bytes_next;
        plan_valid <= 1'b1;
        plan <= pl;
      end
    end
  end

endmodule

@@ design/snfs_back.sv @@
// back part: holds planned items in a short queue and emits results one a cycle while popped and not empty
// depends on snfs_pkg
module snfs_back import snfs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  plan_valid,
  output logic  plan_ready,
  input  plan_t plan,
  output logic  empty,
  input  logic  pop,
  output res_t  res
);

  // two-entry plan queue
  plan_t      q [2];
  logic       wp, rp;
  logic [1:0] fill;
  logic [2:0] idx;
  logic       take, done_one;

  assign plan_ready = fill != 2'd2;
  assign empty = fill == 2'd0;
  assign res = q[rp].res[idx];
  assign take = plan_valid && plan_ready;
  assign done_one = pop && !empty && (4'({1'b0, idx}) + 4'd1 == q[rp].cnt);

  always_ff @(posedge clk) begin
    if (take) q[wp] <= plan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
      idx <= '0;
    end else begin
      if (take) wp <= !wp;
      if (pop && !empty) begin
        if (done_one) begin
          idx <= '0;
          rp <= !rp;
        end else begin
          idx <= idx + 3'd1;
        end
      end
      fill <= fill + 2'(take) - 2'(done_one);
    end
  end

endmodule
